>>> rtl/core/lfr_pkg.sv
// Shared constants for the line and frame receiver: defaults, command and register codes.
package lfr_pkg;

   // Default sizes of one buffer bank and of one fixed-length frame.
   localparam int BUF_BYTES_DEF   = 64;
   localparam int FRAME_BYTES_DEF = 9;

   // Control characters of text lines.
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Reset value of the frame header register.
   localparam logic [7:0] HEADER_RESET = 8'd89;

   // Field widths of the ports.
   localparam int CMD_W     = 2;
   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 6;
   localparam int LENGTH_W  = 7;
   localparam int CSR_IDX_W = 2;

   // Command codes of the request channel.
   localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STATUS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER     = 2'd1;

endpackage

>>> rtl/core/line_frame_receiver.sv
// Top level of the line and frame receiver with its ping-pong bank memory.
// A status or read transaction shows its response in the cycle after acceptance.
// Throughput: one request transaction per cycle; a status or read transaction waits only
// while a stalled response holds the register. Each stored byte is one memory write and
// each in-range read is one memory read, on separate ports of the bank memory.
// Reset clears the fill count, bank select, length, flags, frame mode and the response valid, and
// loads the header reset value; the bank memory and the response payload hold unknown data until written.
module line_frame_receiver #(
   parameter int BUF_BYTES   = lfr_pkg::BUF_BYTES_DEF,
   parameter int FRAME_BYTES = lfr_pkg::FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lfr_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lfr_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic [lfr_pkg::INDEX_W-1:0]   req_read_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_line_ready,
   output logic                          rsp_overflow,
   output logic [lfr_pkg::LENGTH_W-1:0]  rsp_line_length,
   output logic [lfr_pkg::BYTE_W-1:0]    rsp_read_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lfr_pkg::BYTE_W-1:0]    csr_data
);
   import lfr_pkg::*;

   // Offset bits within a bank, fill count bits, and a compare width wide enough for all.
   localparam int AW = $clog2(BUF_BYTES);
   localparam int FW = $clog2(BUF_BYTES + 1);
   localparam int CW = (FW > LENGTH_W) ? FW : LENGTH_W;
   localparam int DEPTH = 2 ** (AW + 1);

   // Configuration registers.
   logic             frame_mode_ff;
   logic [BYTE_W-1:0] header_byte_ff;

   // Receive state.
   logic [FW-1:0] fill_count_ff, fill_count_in;
   logic          active_bank_ff, active_bank_in;
   logic [FW-1:0] done_length_ff, done_length_in;
   logic          ready_flag_ff, ready_flag_in;
   logic          overrun_flag_ff, overrun_flag_in;

   // Bank memory and its registered read port.
   logic [BYTE_W-1:0] bank_store_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [AW:0]       wr_addr;
   logic              rd_en;
   logic [AW:0]       rd_addr;

   // Response register.
   logic                out_valid_ff, out_valid_in;
   logic                out_ready_ff;
   logic                out_overflow_ff;
   logic [LENGTH_W-1:0] out_length_ff;
   logic                out_use_mem_ff;

   logic          has_rsp;
   logic          req_accept;
   logic [CW-1:0] fill_ext;
   logic [CW-1:0] index_ext;
   logic          read_in_range;

   // Handshake: bytes are taken even while a response waits; queries need the register.
   assign has_rsp    = (req_cmd == CMD_STATUS) || (req_cmd == CMD_READ);
   assign req_stall  = out_valid_ff && rsp_stall && has_rsp;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign fill_ext      = CW'(fill_count_ff);
   assign index_ext     = CW'(req_read_index);
   assign read_in_range = (index_ext < CW'(done_length_ff)) && (index_ext < CW'(BUF_BYTES));

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff  <= 1'b0;
         header_byte_ff <= HEADER_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_MODE: frame_mode_ff  <= csr_data[0];
            CSR_HEADER:     header_byte_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Byte handling, flag clearing and memory address generation.
   always_comb begin
      fill_count_in   = fill_count_ff;
      active_bank_in  = active_bank_ff;
      done_length_in  = done_length_ff;
      ready_flag_in   = ready_flag_ff;
      overrun_flag_in = overrun_flag_ff;
      wr_en           = 1'b0;
      wr_addr         = {active_bank_ff, AW'(fill_count_ff)};
      rd_en           = 1'b0;
      rd_addr         = {~active_bank_ff, AW'(req_read_index)};
      if (req_accept) begin
         case (req_cmd)
            CMD_BYTE: begin
               if (!frame_mode_ff) begin
                  // Text line: drop CR, finish on LF, restart on overrun.
                  if (fill_ext < CW'(BUF_BYTES)) begin
                     if (req_rx_byte != CH_CR) begin
                        wr_en         = 1'b1;
                        fill_count_in = FW'(fill_count_ff + FW'(1));
                     end
                     if (req_rx_byte == CH_LF) begin
                        ready_flag_in  = 1'b1;
                        done_length_in = FW'(fill_count_ff + FW'(1));
                        active_bank_in = ~active_bank_ff;
                        fill_count_in  = '0;
                     end
                  end else begin
                     overrun_flag_in = 1'b1;
                     fill_count_in   = '0;
                  end
               end else begin
                  // Headed frame: check the two header positions, finish at full length.
                  if ((req_rx_byte != header_byte_ff) && (fill_ext < CW'(2))) begin
                     fill_count_in = '0;
                  end else if ((fill_ext < CW'(FRAME_BYTES)) && (fill_ext < CW'(BUF_BYTES))) begin
                     wr_en         = 1'b1;
                     fill_count_in = FW'(fill_count_ff + FW'(1));
                     if (fill_ext + CW'(1) == CW'(FRAME_BYTES)) begin
                        ready_flag_in  = 1'b1;
                        done_length_in = FW'(fill_count_ff + FW'(1));
                        active_bank_in = ~active_bank_ff;
                        fill_count_in  = '0;
                     end
                  end else begin
                     fill_count_in = '0;
                  end
               end
            end
            CMD_STATUS: begin
               ready_flag_in   = 1'b0;
               overrun_flag_in = 1'b0;
            end
            CMD_READ: begin
               rd_en = read_in_range;
            end
            default: ;
         endcase
      end
   end

   // Receive state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff   <= '0;
         active_bank_ff  <= 1'b0;
         done_length_ff  <= '0;
         ready_flag_ff   <= 1'b0;
         overrun_flag_ff <= 1'b0;
      end else begin
         fill_count_ff   <= fill_count_in;
         active_bank_ff  <= active_bank_in;
         done_length_ff  <= done_length_in;
         ready_flag_ff   <= ready_flag_in;
         overrun_flag_ff <= overrun_flag_in;
      end
   end

   // Bank memory: the write goes to the filling bank, the read to the completed one.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_store_ff[wr_addr] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= bank_store_ff[rd_addr];
      end
   end

   // Response register valid.
   always_comb begin
      if (req_accept && has_rsp) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Response payload, loaded with each accepted query.
   always_ff @(posedge clock) begin
      if (req_accept && has_rsp) begin
         if (req_cmd == CMD_STATUS) begin
            out_ready_ff    <= ready_flag_ff;
            out_overflow_ff <= overrun_flag_ff;
            out_length_ff   <= overrun_flag_ff ? '0 : LENGTH_W'(done_length_ff);
            out_use_mem_ff  <= 1'b0;
         end else begin
            out_ready_ff    <= 1'b0;
            out_overflow_ff <= 1'b0;
            out_length_ff   <= '0;
            out_use_mem_ff  <= read_in_range;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_line_ready  = out_ready_ff;
   assign rsp_overflow    = out_overflow_ff;
   assign rsp_line_length = out_length_ff;
   assign rsp_read_data   = out_use_mem_ff ? rd_data_ff : '0;

endmodule

>>> rtl/core/lfr_checker.sv
// Port-level checker for the line and frame receiver and its bind to the top level.
module lfr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [lfr_pkg::CMD_W-1:0]     req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_line_ready,
   input logic                          rsp_overflow,
   input logic [lfr_pkg::LENGTH_W-1:0]  rsp_line_length,
   input logic [lfr_pkg::BYTE_W-1:0]    rsp_read_data
);
   import lfr_pkg::*;

   // A stalled response transaction stays offered.
   assert property (@(posedge clock) disable iff (reset) rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // The response register is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An accepted status or read transaction shows a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && ((req_cmd == CMD_STATUS) || (req_cmd == CMD_READ))
      |=> rsp_valid)
      else $error("query accepted without a response");

   // An overflow report carries no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_line_length == '0)
      else $error("length reported with overflow");

   // Read data only comes with a read response, which carries no status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data != '0)
      |-> !rsp_line_ready && !rsp_overflow && (rsp_line_length == '0))
      else $error("status and read data mixed in one response");

endmodule

bind line_frame_receiver lfr_checker u_lfr_checker (.*);
